// ===== design/lkv_pkg.sv =====
// lkv_pkg: shared sizes, codes, types and the update record of the LRU
// key-value cache. No dependencies.
package lkv_pkg;

  localparam int WAYS       = 16;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 20;
  localparam int CFG_BITS   = 5;

  localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_BITS = WAY_BITS;
  localparam int CAP_BITS  = $clog2(WAYS + 1);

  localparam int IN_DATA_BITS  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

  localparam int CAP_RESET = (WAYS < 16) ? WAYS : 16;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef logic [WAY_BITS-1:0]   way_t;
  typedef logic [RANK_BITS-1:0]  rank_t;
  typedef logic [CAP_BITS-1:0]   cap_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CFG_BITS-1:0]   cfg_t;

  typedef logic [WAYS-1:0][KEY_BITS-1:0]   key_arr_t;
  typedef logic [WAYS-1:0][VALUE_BITS-1:0] value_arr_t;
  typedef logic [WAYS-1:0][RANK_BITS-1:0]  rank_arr_t;
  typedef logic [WAYS-1:0]                 valid_vec_t;

  // fill: new way ages every valid way; otherwise the way is touched
  typedef struct packed {
    logic   en;
    logic   fill;
    logic   wr_key;
    logic   wr_value;
    way_t   way;
    key_t   key;
    value_t value;
  } upd_t;

endpackage

// ===== design/lkv_lookup.sv =====
// lkv_lookup: parallel key compare, free-way and victim selection, read data.
// Depends on lkv_pkg.
module lkv_lookup (
  input  logic                action_i,
  input  lkv_pkg::key_t       key_i,
  input  lkv_pkg::value_t     value_i,
  input  lkv_pkg::cap_t       cap_i,
  input  lkv_pkg::key_arr_t   keys_i,
  input  lkv_pkg::value_arr_t values_i,
  input  lkv_pkg::rank_arr_t  ranks_i,
  input  lkv_pkg::valid_vec_t valid_i,
  output logic                hit_o,
  output lkv_pkg::value_t     read_value_o,
  output lkv_pkg::upd_t       upd_o
);
  import lkv_pkg::*;

  function automatic way_t first_set(logic [WAYS-1:0] v);
    way_t idx;
    idx = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (v[i]) idx = way_t'(i);
    end
    return idx;
  endfunction

  logic [WAYS-1:0] in_cap, match, free_vec, victim_vec;
  rank_t           oldest;
  way_t            found_way, free_way, victim_way;
  logic            free_any;

  // ranks of a full cache form 0..cap-1, so the oldest way has rank cap-1
  assign oldest = rank_t'(cap_i - cap_t'(1));

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      in_cap[i]     = (32'(cap_i) > i);
      match[i]      = in_cap[i] && valid_i[i] && (keys_i[i] == key_i);
      free_vec[i]   = in_cap[i] && !valid_i[i];
      victim_vec[i] = in_cap[i] && (ranks_i[i] == oldest);
    end
  end

  assign found_way  = first_set(match);
  assign free_way   = first_set(free_vec);
  assign victim_way = first_set(victim_vec);
  assign free_any   = |free_vec;
  assign hit_o      = |match;

  assign read_value_o = (hit_o && action_i == ACT_GET) ? values_i[found_way] : '0;

  always_comb begin
    upd_o.en       = hit_o || (action_i == ACT_PUT);
    upd_o.fill     = !hit_o && free_any;
    upd_o.wr_key   = !hit_o;
    upd_o.wr_value = (action_i == ACT_PUT);
    upd_o.way      = hit_o ? found_way : (free_any ? free_way : victim_way);
    upd_o.key      = key_i;
    upd_o.value    = value_i;
  end

endmodule

// ===== design/lkv_store.sv =====
// lkv_store: key, value, valid and recency-rank registers plus the capacity
// register. Depends on lkv_pkg.
module lkv_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  lkv_pkg::cfg_t       cfg_wdata_i,
  input  lkv_pkg::upd_t       upd_i,
  output lkv_pkg::cap_t       cap_o,
  output lkv_pkg::key_arr_t   keys_o,
  output lkv_pkg::value_arr_t values_o,
  output lkv_pkg::rank_arr_t  ranks_o,
  output lkv_pkg::valid_vec_t valid_o
);
  import lkv_pkg::*;

  cap_t       cap_q, cap_d;
  key_arr_t   keys_q;
  value_arr_t values_q;
  rank_arr_t  rank_q, rank_d;
  valid_vec_t valid_q, valid_d;
  rank_t      old_rank;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cap_d = cap_t'(1);
    end else if (32'(cfg_wdata_i) > WAYS) begin
      cap_d = cap_t'(WAYS);
    end else begin
      cap_d = cap_t'(cfg_wdata_i);
    end
  end

  assign old_rank = rank_q[upd_i.way];

  always_comb begin
    rank_d  = rank_q;
    valid_d = valid_q;
    if (upd_i.en) begin
      for (int i = 0; i < WAYS; i++) begin
        if (upd_i.fill) begin
          if (valid_q[i] && 32'(rank_q[i]) < WAYS - 1) rank_d[i] = rank_q[i] + rank_t'(1);
        end else if (valid_q[i] && way_t'(i) != upd_i.way && rank_q[i] < old_rank) begin
          rank_d[i] = rank_q[i] + rank_t'(1);
        end
      end
      rank_d[upd_i.way]  = '0;
      valid_d[upd_i.way] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= cap_t'(CAP_RESET);
      valid_q <= '0;
      rank_q  <= '0;
    end else if (cfg_we_i) begin
      cap_q   <= cap_d;
      valid_q <= '0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.en && upd_i.wr_key) keys_q[upd_i.way] <= upd_i.key;
    if (upd_i.en && upd_i.wr_value) values_q[upd_i.way] <= upd_i.value;
  end

  assign cap_o    = cap_q;
  assign keys_o   = keys_q;
  assign values_o = values_q;
  assign ranks_o  = rank_q;
  assign valid_o  = valid_q;

`ifndef ASSERT_OFF
  logic [WAYS-1:0] cap_mask;
  always_comb begin
    for (int i = 0; i < WAYS; i++) cap_mask[i] = (32'(cap_q) > i);
  end

  a_valid_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q & ~cap_mask) == '0)
    else $error("valid way outside capacity");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> valid_q == '0)
    else $error("capacity write did not invalidate entries");

  a_rank_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_i.en || !valid_q[upd_i.way] || 32'(old_rank) < $countones(valid_q))
    else $error("rank of updated way out of range");
`endif

endmodule

// ===== design/lru_key_value_cache_top.sv =====
// lru_key_value_cache_top: stream top level of the LRU key-value cache.
// Depends on lkv_pkg, lkv_lookup and lkv_store.
//
// Fully associative 16-way key-value cache with least-recently-used
// replacement. One transfer is accepted per clock while the result side
// does not stall: the item is registered, then all ways are compared in
// parallel and the state and result register are updated once the result
// register can advance. The result is held until it is taken. The throughput
// is one item per cycle when not stalled, set by the parallel compare and rank
// update. A stall on the result side holds the pipeline. Writing the capacity
// invalidates every entry; write it only while idle.
module lru_key_value_cache_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  lkv_pkg::cfg_t                      cfg_wdata_i,   // ways_in_use
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lkv_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,  // key, value
  input  logic                               s_axis_tuser,  // action
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [lkv_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,  // read_value
  output logic                               m_axis_tuser   // hit
);
  import lkv_pkg::*;

  logic       s1_valid_q, s1_act_q;
  key_t       s1_key_q;
  value_t     s1_value_q;
  logic       out_valid_q, out_hit_q;
  value_t     out_value_q;
  logic       adv, fire, lk_hit;
  value_t     lk_value;
  upd_t       lk_upd, st_upd;
  cap_t       cap;
  key_arr_t   keys;
  value_arr_t values;
  rank_arr_t  ranks;
  valid_vec_t valid;

  assign adv           = !out_valid_q || m_axis_tready;
  assign fire          = s1_valid_q && adv;
  assign s_axis_tready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) s1_valid_q <= s_axis_tvalid;
      if (adv) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_act_q   <= s_axis_tuser;
      s1_key_q   <= s_axis_tdata[KEY_BITS-1:0];
      s1_value_q <= s_axis_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
    end
    if (fire) begin
      out_hit_q   <= lk_hit;
      out_value_q <= lk_value;
    end
  end

  lkv_lookup u_lookup (
    .action_i     (s1_act_q),
    .key_i        (s1_key_q),
    .value_i      (s1_value_q),
    .cap_i        (cap),
    .keys_i       (keys),
    .values_i     (values),
    .ranks_i      (ranks),
    .valid_i      (valid),
    .hit_o        (lk_hit),
    .read_value_o (lk_value),
    .upd_o        (lk_upd)
  );

  always_comb begin
    st_upd    = lk_upd;
    st_upd.en = lk_upd.en && fire;
  end

  lkv_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .upd_i       (st_upd),
    .cap_o       (cap),
    .keys_o      (keys),
    .values_o    (values),
    .ranks_o     (ranks),
    .valid_o     (valid)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = OUT_DATA_BITS'(out_value_q);

`ifndef ASSERT_OFF
  a_fire_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed item did not reach result register");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

  a_no_update_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !st_upd.en)
    else $error("state updated without an item");
`endif

endmodule
